// ===== hdl/rad_pkg.sv =====
// Shared types and codes for the rectangle-add difference array block.
// No dependencies; imported by the top level and the sequencer of the block.
package rad_pkg;

    // Action codes of an input request
    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_REBUILD = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam int CFG_BITS = 6;
    localparam int COORD_BITS = 5;
    localparam int IO_VALUE_BITS = 32;

    // Configuration registers as seen by the sequencer
    typedef struct packed {
        logic [CFG_BITS-1:0] rows_in_use;
        logic [CFG_BITS-1:0] cols_in_use;
    } cfg_t;

    // One input request
    typedef struct packed {
        logic [1:0]               action;
        logic [COORD_BITS-1:0]    top_row;
        logic [COORD_BITS-1:0]    left_col;
        logic [COORD_BITS-1:0]    bottom_row;
        logic [COORD_BITS-1:0]    right_col;
        logic [IO_VALUE_BITS-1:0] add_value;
        logic [COORD_BITS-1:0]    read_row;
        logic [COORD_BITS-1:0]    read_col;
    } req_t;

    // One result
    typedef struct packed {
        logic [IO_VALUE_BITS-1:0] read_value;
        logic                     status;
    } res_t;

endpackage

// ===== hdl/rect_add_2d_difference_array_top.sv =====
// Top level of the rectangle-add difference array: configuration registers,
// result output register and the sequencer. Uses rad_pkg and rad_seq.
//
// Usage:
//   Requests arrive on the s_ valid/ready channel, one result per request
//   leaves on the m_ channel. Configuration (rows/columns in use) is to be
//   written on cfg_wr_en/cfg_index/cfg_wdata only while the block is idle;
//   the block itself does not enforce this. One request is processed at a
//   time; steps from acceptance until the result is loaded into the output register:
//     read: read the final matrix, then take its data; rejected add or read: none,
//     add: a read and a write per corner written, only the read per corner skipped,
//     clear: all MAX_ROWS*MAX_COLS cells, one cell per cycle on the diff memory port,
//     rebuild: read, row add, column add and write for each of rows * cols
//     cells through one shared adder.
//   m_valid rises at the same edge that loads the result.
//   After reset both matrices are cleared by a pass over all MAX_ROWS*MAX_COLS
//   cells during which s_ready is low; configuration writes are still taken.
//   A stalled m_ready holds the result; the next request may be accepted and
//   processed, its result waits until the output register is free.
module rect_add_2d_difference_array_top
    import rad_pkg::*;
#(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [5:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_action,
    input  logic [4:0]          s_top_row,
    input  logic [4:0]          s_left_col,
    input  logic [4:0]          s_bottom_row,
    input  logic [4:0]          s_right_col,
    input  logic signed [31:0]  s_add_value,
    input  logic [4:0]          s_read_row,
    input  logic [4:0]          s_read_col,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_read_value,
    output logic                m_status
);

    cfg_t cfg_reg;
    req_t in_req;
    res_t res;
    logic res_valid, res_ready;
    logic out_valid_reg;
    logic [IO_VALUE_BITS-1:0] out_value_reg;
    logic out_status_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rows_in_use <= CFG_BITS'(32);
            cfg_reg.cols_in_use <= CFG_BITS'(32);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROWS: cfg_reg.rows_in_use <= cfg_wdata;
                CFG_COLS: cfg_reg.cols_in_use <= cfg_wdata;
            endcase
        end
    end

    // Pack the request
    assign in_req.action     = s_action;
    assign in_req.top_row    = s_top_row;
    assign in_req.left_col   = s_left_col;
    assign in_req.bottom_row = s_bottom_row;
    assign in_req.right_col  = s_right_col;
    assign in_req.add_value  = s_add_value;
    assign in_req.read_row   = s_read_row;
    assign in_req.read_col   = s_read_col;

    rad_seq #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_value_reg  <= res.read_value;
            out_status_reg <= res.status;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_status     = out_status_reg;

endmodule

// ===== hdl/rad_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies on the package.
module rad_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/rad_alu.sv =====
// Shared add/subtract unit, wraps modulo 2^WIDTH.
// No dependencies on the package.
module rad_alu #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum
);

    logic [WIDTH-1:0] b_eff;

    // Subtract as a plus inverted b plus one
    assign b_eff = sub ? ~op_b : op_b;
    assign sum   = op_a + b_eff + WIDTH'(sub);

endmodule

// ===== hdl/rad_seq.sv =====
// Sequencer and datapath: owns both matrices, walks sweeps, corner updates
// and the rebuild pass. Uses rad_pkg, rad_ram and rad_alu.
module rad_seq
    import rad_pkg::*;
#(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RCW   = (MAX_ROWS > 64) ? CFG_BITS : $clog2(MAX_ROWS);
    localparam int CCW   = (MAX_COLS > 64) ? CFG_BITS : $clog2(MAX_COLS);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLEAR, S_ADD_RD, S_ADD_WR,
        S_RB_RD, S_RB_ROW, S_RB_COL, S_RD_RD, S_RD_DATA, S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           sweep_reg, sweep_next;
    logic [1:0]              corner_reg, corner_next;
    logic                    below_reg, below_next;
    logic                    right_reg, right_next;
    logic [COORD_BITS-1:0]   t_reg, t_next, l_reg, l_next;
    logic [COORD_BITS-1:0]   b_reg, b_next, r_reg, r_next;
    logic [COORD_BITS-1:0]   rr_reg, rr_next, rc_reg, rc_next;
    logic [VALUE_BITS-1:0]   v_reg, v_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [RCW-1:0]          row_reg, row_next;
    logic [CCW-1:0]          col_reg, col_next;
    logic [IO_VALUE_BITS-1:0] value_reg, value_next;
    logic                    status_reg, status_next;

    logic [CFG_BITS-1:0] nr, nc;
    logic                accept, add_bad, read_bad, sweep_last;
    logic                row_last, col_last, corner_en;
    logic [CFG_BITS-1:0] crow, ccol;
    logic [RCW-1:0]      prev_row;
    logic [AW-1:0]       corner_addr;
    logic signed [63:0]  av_ext;

    logic                  d_we, d_re, f_we, f_re;
    logic [AW-1:0]         d_waddr, d_raddr, f_waddr, f_raddr;
    logic [VALUE_BITS-1:0] d_wdata, f_wdata, d_rdata, f_rdata;
    logic [VALUE_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                  alu_sub;

    function automatic logic [AW-1:0] cell_addr(input logic [CFG_BITS-1:0] row,
                                                input logic [CFG_BITS-1:0] col);
        return AW'(32'(row) * MAX_COLS + 32'(col));
    endfunction

    // Dimensions in use, saturated to 1..MAX
    always_comb begin
        nr = cfg.rows_in_use;
        nc = cfg.cols_in_use;
        if (cfg.rows_in_use == '0) begin
            nr = CFG_BITS'(1);
        end else if (32'(cfg.rows_in_use) > MAX_ROWS) begin
            nr = CFG_BITS'(MAX_ROWS);
        end
        if (cfg.cols_in_use == '0) begin
            nc = CFG_BITS'(1);
        end else if (32'(cfg.cols_in_use) > MAX_COLS) begin
            nc = CFG_BITS'(MAX_COLS);
        end
    end

    // Request checks and helpers
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign add_bad    = (in_req.top_row > in_req.bottom_row)
                     || (in_req.left_col > in_req.right_col)
                     || (CFG_BITS'(in_req.bottom_row) >= nr)
                     || (CFG_BITS'(in_req.right_col) >= nc);
    assign read_bad   = (CFG_BITS'(in_req.read_row) >= nr)
                     || (CFG_BITS'(in_req.read_col) >= nc);
    assign av_ext     = 64'($signed(in_req.add_value));
    assign sweep_last = (sweep_reg == AW'(CELLS - 1));
    assign row_last   = (CFG_BITS'(row_reg) == nr - CFG_BITS'(1));
    assign col_last   = (CFG_BITS'(col_reg) == nc - CFG_BITS'(1));
    assign prev_row   = (row_reg == '0) ? '0 : row_reg - RCW'(1);

    // Corner of the four-corner update
    assign crow = corner_reg[0] ? CFG_BITS'(b_reg) + CFG_BITS'(1) : CFG_BITS'(t_reg);
    assign ccol = corner_reg[1] ? CFG_BITS'(r_reg) + CFG_BITS'(1) : CFG_BITS'(l_reg);
    assign corner_addr = cell_addr(crow, ccol);
    always_comb begin
        case (corner_reg)
            2'd0:    corner_en = 1'b1;
            2'd1:    corner_en = below_reg;
            2'd2:    corner_en = right_reg;
            default: corner_en = below_reg && right_reg;
        endcase
    end

    // Memory ports and shared adder operands
    always_comb begin
        d_we    = 1'b0;
        d_waddr = sweep_reg;
        d_wdata = '0;
        d_re    = 1'b0;
        d_raddr = corner_addr;
        f_we    = 1'b0;
        f_waddr = sweep_reg;
        f_wdata = '0;
        f_re    = 1'b0;
        f_raddr = cell_addr(CFG_BITS'(rr_reg), CFG_BITS'(rc_reg));
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                d_we = 1'b1;
                f_we = 1'b1;
            end
            S_CLEAR: begin
                d_we = 1'b1;
            end
            S_ADD_RD: begin
                d_re = corner_en;
            end
            S_ADD_WR: begin
                alu_a   = d_rdata;
                alu_b   = v_reg;
                alu_sub = (corner_reg == 2'd1) || (corner_reg == 2'd2);
                d_we    = 1'b1;
                d_waddr = corner_addr;
                d_wdata = alu_sum;
            end
            S_RB_RD: begin
                d_re    = 1'b1;
                d_raddr = cell_addr(CFG_BITS'(row_reg), CFG_BITS'(col_reg));
                f_re    = 1'b1;
                f_raddr = cell_addr(CFG_BITS'(prev_row), CFG_BITS'(col_reg));
            end
            S_RB_ROW: begin
                alu_a = (col_reg == '0) ? '0 : acc_reg;
                alu_b = d_rdata;
            end
            S_RB_COL: begin
                alu_a   = acc_reg;
                alu_b   = (row_reg == '0) ? '0 : f_rdata;
                f_we    = 1'b1;
                f_waddr = cell_addr(CFG_BITS'(row_reg), CFG_BITS'(col_reg));
                f_wdata = alu_sum;
            end
            S_RD_RD: begin
                f_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next-state logic
    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        corner_next = corner_reg;
        below_next  = below_reg;
        right_next  = right_reg;
        t_next      = t_reg;
        l_next      = l_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        rr_next     = rr_reg;
        rc_next     = rc_reg;
        v_next      = v_reg;
        acc_next    = acc_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        value_next  = value_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_INIT: begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    t_next      = in_req.top_row;
                    l_next      = in_req.left_col;
                    b_next      = in_req.bottom_row;
                    r_next      = in_req.right_col;
                    rr_next     = in_req.read_row;
                    rc_next     = in_req.read_col;
                    v_next      = av_ext[VALUE_BITS-1:0];
                    below_next  = (CFG_BITS'(in_req.bottom_row) + CFG_BITS'(1)) < nr;
                    right_next  = (CFG_BITS'(in_req.right_col) + CFG_BITS'(1)) < nc;
                    corner_next = 2'd0;
                    sweep_next  = '0;
                    row_next    = '0;
                    col_next    = '0;
                    value_next  = '0;
                    status_next = 1'b0;
                    unique case (action_t'(in_req.action))
                        ACT_CLEAR: state_next = S_CLEAR;
                        ACT_ADD: begin
                            if (add_bad) begin
                                status_next = 1'b1;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_ADD_RD;
                            end
                        end
                        ACT_REBUILD: state_next = S_RB_RD;
                        ACT_READ: begin
                            if (read_bad) begin
                                status_next = 1'b1;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_RD_RD;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_ADD_RD: begin
                if (corner_en) begin
                    state_next = S_ADD_WR;
                end else if (corner_reg == 2'd3) begin
                    state_next = S_DONE;
                end else begin
                    corner_next = corner_reg + 2'd1;
                end
            end
            S_ADD_WR: begin
                if (corner_reg == 2'd3) begin
                    state_next = S_DONE;
                end else begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = S_ADD_RD;
                end
            end
            S_RB_RD: begin
                state_next = S_RB_ROW;
            end
            S_RB_ROW: begin
                acc_next   = alu_sum;
                state_next = S_RB_COL;
            end
            S_RB_COL: begin
                state_next = S_RB_RD;
                if (col_last) begin
                    col_next = '0;
                    row_next = row_reg + RCW'(1);
                    if (row_last) begin
                        state_next = S_DONE;
                    end
                end else begin
                    col_next = col_reg + CCW'(1);
                end
            end
            S_RD_RD: begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA: begin
                value_next = IO_VALUE_BITS'($signed(f_rdata));
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
        end
        corner_reg <= corner_next;
        below_reg  <= below_next;
        right_reg  <= right_next;
        t_reg      <= t_next;
        l_reg      <= l_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        rr_reg     <= rr_next;
        rc_reg     <= rc_next;
        v_reg      <= v_next;
        acc_reg    <= acc_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign res_valid      = (state_reg == S_DONE);
    assign res.read_value = value_reg;
    assign res.status     = status_reg;

    // Difference matrix
    rad_ram #(.DEPTH(CELLS), .WIDTH(VALUE_BITS)) u_diff (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // Final matrix
    rad_ram #(.DEPTH(CELLS), .WIDTH(VALUE_BITS)) u_final (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // Shared adder
    rad_alu #(.WIDTH(VALUE_BITS)) u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum)
    );

`ifndef NO_ASSERTIONS
    // No request is taken while the memories are being cleared after reset
    a_init_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !in_ready)
        else $error("request taken during reset clear");

    // A rejected request never carries a cell value
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status) |-> (res.read_value == '0))
        else $error("rejected result with nonzero value");

    // Difference matrix is written only by sweeps and corner updates
    a_diff_write: assert property (@(posedge aclk) disable iff (!aresetn)
        d_we |-> (state_reg == S_INIT || state_reg == S_CLEAR
                  || state_reg == S_ADD_WR))
        else $error("unexpected difference matrix write");

    // Rebuild writes stay inside the region in use
    a_rb_region: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_we && state_reg == S_RB_COL)
            |-> (CFG_BITS'(row_reg) < nr && CFG_BITS'(col_reg) < nc))
        else $error("rebuild write outside region");

    // One request at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !in_ready)
        else $error("ready right after a request");
`endif

endmodule

// ===== verif/rad_tb_pkg.sv =====
// Scoreboard class for the rectangle-add difference array testbench.
// Depends on rad_pkg for the action codes, register indexes and request/result types.
package rad_tb_pkg;
    import rad_pkg::*;

    localparam int GRID_ROWS  = 32;
    localparam int GRID_COLS  = 32;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

    // Tracks both matrices and the two dimension registers, and holds the
    // results still owed by the block, oldest first.
    class rect_sum_board;
        logic [31:0]         diff_cells  [GRID_CELLS];
        logic [31:0]         final_cells [GRID_CELLS];
        logic [CFG_BITS-1:0] rows_reg;
        logic [CFG_BITS-1:0] cols_reg;
        res_t                owed_results [$];
        int unsigned         mismatches;

        function new();
            foreach (diff_cells[k]) begin
                diff_cells[k]  = '0;
                final_cells[k] = '0;
            end
            rows_reg   = 6'd32;
            cols_reg   = 6'd32;
            mismatches = 0;
        endfunction

        // Register value saturated to 1..GRID_ROWS; zero behaves as one
        function int unsigned rows_used();
            if (rows_reg == 0) return 1;
            if (rows_reg > GRID_ROWS) return GRID_ROWS;
            return 32'(rows_reg);
        endfunction

        function int unsigned cols_used();
            if (cols_reg == 0) return 1;
            if (cols_reg > GRID_COLS) return GRID_COLS;
            return 32'(cols_reg);
        endfunction

        function void write_register(logic idx, logic [CFG_BITS-1:0] val);
            if (idx == CFG_ROWS) begin
                rows_reg = val;
            end else begin
                cols_reg = val;
            end
        endfunction

        function void bump(int unsigned row, int unsigned col, logic [31:0] amount);
            diff_cells[row * GRID_COLS + col] = diff_cells[row * GRID_COLS + col] + amount;
        endfunction

        // Update the matrices for one accepted request and queue its result
        function void apply_request(req_t rq);
            res_t        want;
            int unsigned nr, nc, t, l, b, r, rr, rc;
            logic [31:0] v;
            bit          has_below, has_right;
            want = '0;
            nr = rows_used();
            nc = cols_used();
            case (action_t'(rq.action))
                ACT_CLEAR: begin
                    foreach (diff_cells[k]) diff_cells[k] = '0;
                end
                ACT_ADD: begin
                    t = 32'(rq.top_row);
                    l = 32'(rq.left_col);
                    b = 32'(rq.bottom_row);
                    r = 32'(rq.right_col);
                    v = rq.add_value;
                    if (t > b || l > r || b >= nr || r >= nc) begin
                        want.status = 1'b1;
                    end else begin
                        // four-corner rule, corners past the region in use are dropped
                        has_below = (b + 1) < nr;
                        has_right = (r + 1) < nc;
                        bump(t, l, v);
                        if (has_below) bump(b + 1, l, -v);
                        if (has_right) bump(t, r + 1, -v);
                        if (has_below && has_right) bump(b + 1, r + 1, v);
                    end
                end
                ACT_REBUILD: begin
                    // copy, then prefix sums along rows, then along columns
                    for (int i = 0; i < nr; i++)
                        for (int j = 0; j < nc; j++)
                            final_cells[i * GRID_COLS + j] = diff_cells[i * GRID_COLS + j];
                    for (int i = 0; i < nr; i++)
                        for (int j = 1; j < nc; j++)
                            final_cells[i * GRID_COLS + j] += final_cells[i * GRID_COLS + j - 1];
                    for (int j = 0; j < nc; j++)
                        for (int i = 1; i < nr; i++)
                            final_cells[i * GRID_COLS + j] += final_cells[(i - 1) * GRID_COLS + j];
                end
                default: begin
                    rr = 32'(rq.read_row);
                    rc = 32'(rq.read_col);
                    if (rr >= nr || rc >= nc) begin
                        want.status = 1'b1;
                    end else begin
                        want.read_value = final_cells[rr * GRID_COLS + rc];
                    end
                end
            endcase
            owed_results.push_back(want);
        endfunction

        function void flag(string msg);
            $display("%s", msg);
            mismatches++;
        endfunction

        // Compare one result from the block with the oldest owed result
        function void check_outcome(longint unsigned stamp, logic [31:0] got_value,
                                    logic got_status);
            res_t want;
            if (owed_results.size() == 0) begin
                flag($sformatf("%0d ns: unexpected result, expected none, %s %h status %b",
                               stamp, "actual value", got_value, got_status));
                return;
            end
            want = owed_results.pop_front();
            if (got_value !== want.read_value)
                flag($sformatf("%0d ns: read_value mismatch, expected %h, actual %h",
                               stamp, want.read_value, got_value));
            if (got_status !== want.status)
                flag($sformatf("%0d ns: status mismatch, expected %b, actual %b",
                               stamp, want.status, got_status));
        endfunction

        function int unsigned owed();
            return owed_results.size();
        endfunction
    endclass

endpackage

// ===== verif/testbench.sv =====
// Testbench top for rect_add_2d_difference_array_top: directed and random
// requests across several row/column settings, checked by rect_sum_board.
// Depends on rad_pkg, rad_tb_pkg and the block's RTL.
module testbench;
    import rad_pkg::*;
    import rad_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int SETTLE_CYCLES   = 8;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = 1'b0;
    logic [5:0]         cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = '0;
    logic [4:0]         s_top_row = '0;
    logic [4:0]         s_left_col = '0;
    logic [4:0]         s_bottom_row = '0;
    logic [4:0]         s_right_col = '0;
    logic signed [31:0] s_add_value = '0;
    logic [4:0]         s_read_row = '0;
    logic [4:0]         s_read_col = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_read_value;
    logic               m_status;

    rect_sum_board sb;

    // Sender burst/gap and receiver stall settings, changed per phase
    int burst_left = 1;
    int gap_max    = 0;
    int stall_max  = 0;
    int ready_left = 0;

    logic [5:0] plan_rows [9] = '{6'd32, 6'd1, 6'd0,  6'd63, 6'd2, 6'd5, 6'd17, 6'd32, 6'd1};
    logic [5:0] plan_cols [9] = '{6'd32, 6'd1, 6'd63, 6'd0,  6'd2, 6'd7, 6'd3,  6'd1,  6'd32};

    rect_add_2d_difference_array_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_top_row    (s_top_row),
        .s_left_col   (s_left_col),
        .s_bottom_row (s_bottom_row),
        .s_right_col  (s_right_col),
        .s_add_value  (s_add_value),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: alternating ready and stall stretches
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            if (!m_ready || stall_max == 0) begin
                m_ready    = 1'b1;
                ready_left = $urandom_range(1, 30);
            end else begin
                m_ready    = 1'b0;
                ready_left = $urandom_range(1, stall_max);
            end
        end else begin
            ready_left--;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_outcome($time, m_read_value, m_status);
    end

    // Offer one request, hold it until accepted, then maybe pause
    task automatic push_request(input req_t rq);
        @(negedge aclk);
        s_valid      = 1'b1;
        s_action     = rq.action;
        s_top_row    = rq.top_row;
        s_left_col   = rq.left_col;
        s_bottom_row = rq.bottom_row;
        s_right_col  = rq.right_col;
        s_add_value  = rq.add_value;
        s_read_row   = rq.read_row;
        s_read_col   = rq.read_col;
        do @(posedge aclk); while (!s_ready);
        sb.apply_request(rq);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat ($urandom_range(0, gap_max - 1)) @(negedge aclk);
            end
        end
    endtask

    task automatic send(input action_t act, input logic [4:0] t, input logic [4:0] l,
                        input logic [4:0] b, input logic [4:0] r, input logic [31:0] v,
                        input logic [4:0] rr, input logic [4:0] rc);
        req_t rq;
        rq.action     = act;
        rq.top_row    = t;
        rq.left_col   = l;
        rq.bottom_row = b;
        rq.right_col  = r;
        rq.add_value  = v;
        rq.read_row   = rr;
        rq.read_col   = rc;
        push_request(rq);
    endtask

    // Stop sending and wait until every owed result is back
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_register(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly well-formed adds and reads inside the region in use, plus noise
    function automatic req_t pick_request(int unsigned nr, int unsigned nc);
        req_t        rq;
        int unsigned roll;
        rq   = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            rq.action = ACT_CLEAR;
        end else if (roll < 10) begin
            rq.action = ACT_REBUILD;
        end else if (roll < 55) begin
            rq.action = ACT_ADD;
            if ($urandom_range(0, 99) < 85) begin
                rq.bottom_row = 5'($urandom_range(0, nr - 1));
                rq.top_row    = 5'($urandom_range(0, rq.bottom_row));
                rq.right_col  = 5'($urandom_range(0, nc - 1));
                rq.left_col   = 5'($urandom_range(0, rq.right_col));
            end
            case ($urandom_range(0, 5))
                0: rq.add_value = $urandom_range(0, 16) - 8;
                1: begin
                    case ($urandom_range(0, 3))
                        0: rq.add_value = 32'h8000_0000;
                        1: rq.add_value = 32'h7FFF_FFFF;
                        2: rq.add_value = '0;
                        default: rq.add_value = '1;
                    endcase
                end
                default: ;
            endcase
        end else if (roll < 95) begin
            rq.action = ACT_READ;
            if ($urandom_range(0, 99) < 85) begin
                rq.read_row = 5'($urandom_range(0, nr - 1));
                rq.read_col = 5'($urandom_range(0, nc - 1));
            end
        end
        return rq;
    endfunction

    initial begin
        logic [5:0] nrows, ncols;
        sb = new();
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: full 32x32 region
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 0, 0);
        send(ACT_ADD,     0, 0, 31, 31, 32'h7FFF_FFFF, 0, 0);
        send(ACT_ADD,     0, 0, 0, 0, 32'h8000_0000, 0, 0);
        send(ACT_ADD,     31, 31, 31, 31, 32'd1, 0, 0);
        send(ACT_ADD,     5, 7, 20, 9, -32'sd12345, 0, 0);
        send(ACT_ADD,     30, 0, 31, 30, 32'hFFFF_FFFF, 0, 0);
        send(ACT_ADD,     10, 0, 9, 5, 32'd7, 0, 0);    // top below bottom
        send(ACT_ADD,     0, 10, 5, 9, 32'd7, 0, 0);    // left past right
        send(ACT_REBUILD, 0, 0, 0, 0, 32'd0, 0, 0);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 0, 0);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 31, 31);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 10, 8);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 31, 0);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 0, 31);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 20, 9);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 21, 10);
        send(ACT_CLEAR,   0, 0, 0, 0, 32'd0, 0, 0);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 10, 8);    // final matrix survives clear
        settle();

        // Directed: 3x4 region, out-of-range rectangles and reads
        write_reg(CFG_ROWS, 6'd3);
        write_reg(CFG_COLS, 6'd4);
        send(ACT_ADD,     0, 0, 3, 1, 32'd5, 0, 0);
        send(ACT_ADD,     0, 0, 1, 4, 32'd5, 0, 0);
        send(ACT_ADD,     1, 1, 2, 3, 32'd9, 0, 0);
        send(ACT_REBUILD, 0, 0, 0, 0, 32'd0, 0, 0);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 2, 3);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 3, 0);
        send(ACT_READ,    0, 0, 0, 0, 32'd0, 0, 4);
        settle();

        // Random phases over several region sizes and idle patterns
        for (int p = 0; p < PHASES; p++) begin
            if (p < 9) begin
                nrows = plan_rows[p];
                ncols = plan_cols[p];
            end else begin
                nrows = 6'($urandom_range(0, 63));
                ncols = 6'($urandom_range(0, 63));
            end
            write_reg(CFG_ROWS, nrows);
            write_reg(CFG_COLS, ncols);
            case ($urandom_range(0, 3))
                0: stall_max = 0;
                1: stall_max = 3;
                2: stall_max = 12;
                default: stall_max = 40;
            endcase
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 6;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_request(pick_request(sb.rows_used(), sb.cols_used()));
            settle();
        end

        if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
